>>> rtl/core/tcrmac_pkg.sv
package tcrmac_pkg;

	localparam int TICK_BITS = 20;
	localparam int SID_BITS  = 8;

	localparam logic [TICK_BITS-1:0] TICK_MAX = '1;
	localparam logic [3:0]           PLY_MAX  = 4'd15;

	// Waiting states, also reported as control_state
	typedef enum logic [3:0] {
		ST_NPACKET  = 4'd0,
		ST_TRANSMIT = 4'd1,
		ST_BUSY     = 4'd2,
		ST_XDONE    = 4'd3,
		ST_COLL     = 4'd4,
		ST_ENDJAM   = 4'd5,
		ST_NEWSLOT  = 4'd6,
		ST_ENDSLOT  = 4'd7,
		ST_EOT      = 4'd8
	} state_t;

	typedef enum logic [2:0] {
		CMD_NONE         = 3'd0,
		CMD_START        = 3'd1,
		CMD_ABORT_JAM    = 3'd2,
		CMD_STOP_JAM     = 3'd3,
		CMD_STOP_RELEASE = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		EV_TICK      = 3'd0,
		EV_ARRIVAL   = 3'd1,
		EV_ACTIVITY  = 3'd2,
		EV_COLLISION = 3'd3,
		EV_BUS_EOP   = 3'd4,
		EV_TX_DONE   = 3'd5
	} event_t;

	typedef enum logic [2:0] {
		REG_STATION_ID = 3'd0,
		REG_SLOT       = 3'd1,
		REG_GUARD      = 3'd2,
		REG_PSPACE     = 3'd3,
		REG_JAM        = 3'd4
	} reg_idx_t;

endpackage

>>> rtl/core/tree_collision_resolution_mac_unit.sv
// Bus station transmitter with tree-tournament collision resolution. Each input word is one
// bus event (tuser) or a timer tick, with the packet-queued flag in tdata; each gives exactly
// one output word: the bus command issued and the station status after the event. One word
// is taken per clock while the output is not stalled; a word passes through the input register
// and then the result register, which holds its result until it is taken. The single state
// update between those registers sets the rate. Configuration writes are always accepted and
// must be issued while no word is in flight.
module tree_collision_resolution_mac_unit
	import tcrmac_pkg::*;
#(
	parameter int ID_BITS    = 8,
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [0] packet_available, [7:1] zero
	input  logic [2:0]  s_axis_tuser,   // [2:0] mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [2:0] command, [3] is_transmitting, [4] in_tournament, [8:5] control_state, [15:9] zero
	output logic [15:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [19:0] cfg_data
);

	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
	localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
	localparam logic [4:0]            ID_LIM  = 5'(ID_BITS);

	// configuration
	logic [SID_BITS-1:0]  station_id_q;
	logic [TICK_BITS-1:0] slot_q, guard_q, pspace_q, jam_q;

	// input stage
	logic       vld_s1;
	logic [2:0] mode_s1;
	logic       pkt_s1;

	// control state
	state_t               phase_q, target_q;
	logic                 tx_q, comp_q, tour_q, armed_q;
	logic [3:0]           ply_q;
	logic [COUNT_BITS-1:0] delay_q, defer_q;
	logic [TICK_BITS-1:0] timer_q;

	// result stage
	logic   vld_s2;
	cmd_t   cmd_s2;
	logic   tx_s2, tour_s2;
	state_t phase_s2;

	// next state
	state_t               nxt_phase, nxt_target, ent_st;
	logic                 nxt_tx, nxt_comp, nxt_tour, nxt_armed, do_enter, go_newslot;
	logic [3:0]           nxt_ply;
	logic [COUNT_BITS-1:0] nxt_delay, nxt_defer;
	logic [TICK_BITS-1:0] nxt_timer;
	cmd_t                 nxt_cmd;
	logic [TICK_BITS:0]   jam_slot;
	logic                 adv, loser;

	assign adv           = vld_s1 && (!vld_s2 || m_axis_tready);
	assign s_axis_tready = !vld_s1 || adv;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = vld_s2;
	assign m_axis_tdata  = {7'd0, phase_s2, tour_s2, tx_s2, cmd_s2};
	assign jam_slot      = {1'b0, jam_q} + {1'b0, slot_q};

	// pick the state that this event wakes
	always_comb begin
		do_enter = 1'b0;
		ent_st   = ST_NPACKET;
		unique case (mode_s1)
			EV_TICK: begin
				if (armed_q && timer_q <= TICK_BITS'(1)) begin
					do_enter = 1'b1;
					ent_st   = (target_q == ST_NPACKET && pkt_s1) ? ST_TRANSMIT : target_q;
				end
			end
			EV_ARRIVAL: begin
				if (phase_q == ST_NPACKET) begin
					do_enter = 1'b1;
					ent_st   = pkt_s1 ? ST_TRANSMIT : ST_NPACKET;
				end
			end
			EV_ACTIVITY: begin
				if (phase_q == ST_NPACKET ||
				    (phase_q == ST_NEWSLOT && !(comp_q && delay_q == '0))) begin
					do_enter = 1'b1;
					ent_st   = ST_BUSY;
				end
			end
			EV_COLLISION: begin
				if (phase_q == ST_TRANSMIT || phase_q == ST_BUSY) begin
					do_enter = 1'b1;
					ent_st   = ST_COLL;
				end
			end
			EV_BUS_EOP: begin
				if (phase_q == ST_BUSY) begin
					do_enter = 1'b1;
					ent_st   = ST_EOT;
				end
			end
			EV_TX_DONE: begin
				if (phase_q == ST_TRANSMIT) begin
					do_enter = 1'b1;
					ent_st   = ST_XDONE;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		nxt_phase  = phase_q;
		nxt_target = target_q;
		nxt_tx     = tx_q;
		nxt_comp   = comp_q;
		nxt_tour   = tour_q;
		nxt_armed  = armed_q;
		nxt_ply    = ply_q;
		nxt_delay  = delay_q;
		nxt_defer  = defer_q;
		nxt_timer  = timer_q;
		nxt_cmd    = CMD_NONE;
		go_newslot = 1'b0;
		loser      = 1'b0;

		if (mode_s1 == EV_TICK && armed_q && timer_q > TICK_BITS'(1))
			nxt_timer = timer_q - TICK_BITS'(1);

		if (do_enter) begin
			nxt_armed = 1'b0;
			nxt_timer = '0;
			unique case (ent_st)
				ST_NPACKET: nxt_phase = ST_NPACKET;
				ST_TRANSMIT: begin
					nxt_tx    = 1'b1;
					nxt_comp  = 1'b1;
					nxt_cmd   = CMD_START;
					nxt_phase = ST_TRANSMIT;
				end
				ST_BUSY: nxt_phase = ST_BUSY;
				ST_COLL: begin
					if (!tour_q) begin
						nxt_ply   = '0;
						nxt_delay = '0;
						nxt_defer = CNT_ONE;
						nxt_tour  = 1'b1;
					end
					if (nxt_defer != CNT_MAX)
						nxt_defer = nxt_defer + CNT_ONE;
					nxt_phase = ST_COLL;
					loser = ({1'b0, nxt_ply} < ID_LIM) && !nxt_ply[3] &&
					        station_id_q[nxt_ply[2:0]];
					if (comp_q && tx_q) begin
						if (loser)
							nxt_delay = CNT_ONE;
						if (nxt_ply != PLY_MAX)
							nxt_ply = nxt_ply + 4'd1;
						nxt_tx     = 1'b0;
						nxt_cmd    = CMD_ABORT_JAM;
						nxt_armed  = 1'b1;
						nxt_timer  = jam_q;
						nxt_target = ST_ENDJAM;
					end else begin
						if (comp_q && nxt_delay != CNT_MAX)
							nxt_delay = nxt_delay + CNT_ONE;
						nxt_armed  = 1'b1;
						nxt_timer  = jam_slot[TICK_BITS] ? TICK_MAX : jam_slot[TICK_BITS-1:0];
						nxt_target = ST_NEWSLOT;
					end
				end
				ST_ENDJAM: begin
					nxt_cmd    = CMD_STOP_JAM;
					nxt_armed  = 1'b1;
					nxt_timer  = slot_q;
					nxt_target = ST_NEWSLOT;
					nxt_phase  = ST_ENDJAM;
				end
				ST_NEWSLOT: go_newslot = 1'b1;
				ST_ENDSLOT: begin
					if (defer_q <= CNT_ONE) begin
						nxt_defer  = '0;
						nxt_tour   = 1'b0;
						nxt_armed  = 1'b1;
						nxt_timer  = guard_q;
						nxt_target = ST_NPACKET;
						nxt_phase  = ST_ENDSLOT;
					end else begin
						nxt_defer = defer_q - CNT_ONE;
						if (comp_q && delay_q != '0)
							nxt_delay = delay_q - CNT_ONE;
						go_newslot = 1'b1;
					end
				end
				default: begin
					// own transmit done releases the bus; it and a bus end of packet then wait out the packet space
					if (ent_st == ST_XDONE) begin
						nxt_cmd  = CMD_STOP_RELEASE;
						nxt_tx   = 1'b0;
						nxt_comp = 1'b0;
					end
					nxt_armed  = 1'b1;
					nxt_timer  = pspace_q;
					nxt_target = tour_q ? ST_ENDSLOT : ST_NPACKET;
					nxt_phase  = ST_EOT;
				end
			endcase

			if (go_newslot) begin
				nxt_armed = 1'b1;
				if (nxt_comp && nxt_delay == '0) begin
					nxt_timer  = guard_q;
					nxt_target = ST_TRANSMIT;
				end else begin
					nxt_timer  = slot_q;
					nxt_target = ST_ENDSLOT;
				end
				nxt_phase = ST_NEWSLOT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_id_q <= '0;
			slot_q       <= TICK_BITS'(64);
			guard_q      <= TICK_BITS'(1);
			pspace_q     <= TICK_BITS'(12);
			jam_q        <= TICK_BITS'(4);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_STATION_ID: station_id_q <= cfg_data[SID_BITS-1:0];
				REG_SLOT:       slot_q       <= cfg_data;
				REG_GUARD:      guard_q      <= cfg_data;
				REG_PSPACE:     pspace_q     <= cfg_data;
				REG_JAM:        jam_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			mode_s1 <= s_axis_tuser;
			pkt_s1  <= s_axis_tdata[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= ST_NPACKET;
			target_q <= ST_NPACKET;
			tx_q     <= 1'b0;
			comp_q   <= 1'b0;
			tour_q   <= 1'b0;
			armed_q  <= 1'b0;
			ply_q    <= '0;
			delay_q  <= '0;
			defer_q  <= '0;
			timer_q  <= '0;
		end else if (adv) begin
			phase_q  <= nxt_phase;
			target_q <= nxt_target;
			tx_q     <= nxt_tx;
			comp_q   <= nxt_comp;
			tour_q   <= nxt_tour;
			armed_q  <= nxt_armed;
			ply_q    <= nxt_ply;
			delay_q  <= nxt_delay;
			defer_q  <= nxt_defer;
			timer_q  <= nxt_timer;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			vld_s2 <= 1'b0;
		end
	end

	// hold the result word until it is taken
	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s2   <= nxt_cmd;
			tx_s2    <= nxt_tx;
			tour_s2  <= nxt_tour;
			phase_s2 <= nxt_phase;
		end
	end

endmodule

>>> rtl/core/tcrmac_checker.sv
module tcrmac_checker
	import tcrmac_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);

	// a stalled result word stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	// own packet is on the bus only in the transmit state
	a_tx_state: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[8:5] == ST_TRANSMIT)
		else $error("transmitting outside transmit state");

	// abort and jam only from a tournament collision, with the transmitter dropped
	a_jam: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2:0] == CMD_ABORT_JAM |->
			m_axis_tdata[4] && !m_axis_tdata[3] && m_axis_tdata[8:5] == ST_COLL)
		else $error("abort and jam with inconsistent status");

	// release leads straight into the end of packet wait
	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2:0] == CMD_STOP_RELEASE |->
			!m_axis_tdata[3] && m_axis_tdata[8:5] == ST_EOT)
		else $error("release with inconsistent status");

endmodule

bind tree_collision_resolution_mac_unit tcrmac_checker u_tcrmac_checker (.*);
